### rtl/pnmrd_pkg.sv
// shared types and constants for the pnm raster decoder
package pnmrd_pkg;

	localparam int MAX_WIDTH = 16384;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);

	localparam int IMG_W_W   = 15;
	localparam int DEPTH_W   = 3;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int NUM_W     = 24;
	localparam int QUO_W     = 8;
	localparam int STEP_W    = $clog2(QUO_W);
	localparam int BITS_W    = 4;
	localparam int HELD_N    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PACKED_BILEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_DEPTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLE     = 2'd3;

	localparam logic [7:0]            FULL_BYTE   = 8'hFF;
	localparam logic [SAMPLE_W-1:0]   MAX_DEFAULT = 16'd255;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_step;
		logic emit_bit;
		logic emit_pixel;
		logic hold_channel;
	} pnmrd_cmd_t;

	typedef struct packed {
		logic bilevel;
		logic first_half;
		logic div_last;
		logic bits_last;
		logic pixel_complete;
		logic out_free;
	} pnmrd_status_t;

endpackage

### rtl/pnmrd_ctrl.sv
// sequencing state machine for the pnm raster decoder
module pnmrd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  pnmrd_pkg::pnmrd_status_t status,
	output pnmrd_pkg::pnmrd_cmd_t    cmd
);
	import pnmrd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_PIX,
		S_BITS
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.bilevel) begin
						state_d = S_BITS;
					end else if (!status.first_half) begin
						state_d = S_PREP;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_PIX;
				end
			end
			S_PIX: begin
				if (!status.pixel_complete) begin
					cmd.hold_channel = 1'b1;
					state_d          = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit_pixel = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_BITS: begin
				if (status.out_free) begin
					cmd.emit_bit = 1'b1;
					if (status.bits_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/pnmrd_datapath.sv
// registers, scaling divider and pixel output register of the pnm raster decoder
module pnmrd_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pnmrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pnmrd_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic [7:0]                           data_byte,
	input  pnmrd_pkg::pnmrd_cmd_t                cmd,
	output pnmrd_pkg::pnmrd_status_t             status,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue,
	output logic [7:0]                           alpha,
	output logic                                 last_of_byte
);
	import pnmrd_pkg::*;

	// configuration
	logic                 packed_bilevel_q;
	logic [IMG_W_W-1:0]   image_width_q;
	logic [DEPTH_W-1:0]   channel_depth_q;
	logic [SAMPLE_W-1:0]  max_sample_q;

	// stream state
	logic [7:0]           high_byte_q;
	logic                 high_pending_q;
	logic [1:0]           channel_index_q;
	logic [COL_W-1:0]     column_q;
	logic [7:0]           held_q [HELD_N];

	// per byte work
	logic [7:0]           shift_q;
	logic [BITS_W-1:0]    bits_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [7:0]           low_q;
	logic [QUO_W-1:0]     quo_q;
	logic [STEP_W-1:0]    step_q;

	// output register
	logic                 out_valid_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;
	logic [7:0]           alpha_q;
	logic                 last_q;

	logic [WID_W-1:0]     width_eff;
	logic [WID_W-1:0]     col_eff;
	logic [WID_W-1:0]     remain;
	logic [BITS_W-1:0]    count;
	logic [WID_W-1:0]     col_next;
	logic [DEPTH_W-1:0]   depth_eff;
	logic                 wide_sample;
	logic [SAMPLE_W-1:0]  raw_sample;
	logic [NUM_W-1:0]     numerator;
	logic [SAMPLE_W:0]    trial;
	logic [7:0]           scaled;
	logic [7:0]           bit_level;

	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WID_W'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			width_eff = WID_W'(MAX_WIDTH);
		end else begin
			width_eff = WID_W'(image_width_q);
		end
		col_eff = (WID_W'(column_q) >= width_eff) ? '0 : WID_W'(column_q);
		remain  = width_eff - col_eff;
		count   = (remain < WID_W'(8)) ? BITS_W'(remain) : BITS_W'(8);
		col_next = col_eff + WID_W'(count);
	end

	always_comb begin
		if (channel_depth_q == '0) begin
			depth_eff = DEPTH_W'(1);
		end else if (channel_depth_q > DEPTH_W'(4)) begin
			depth_eff = DEPTH_W'(4);
		end else begin
			depth_eff = channel_depth_q;
		end
	end

	assign wide_sample = (max_sample_q > MAX_DEFAULT);
	assign raw_sample  = wide_sample ? {high_byte_q, data_byte} : {8'd0, data_byte};

	// v*255 + max/2, below 256*max for a nonzero max so the quotient fits a byte
	assign numerator = {sample_q, 8'd0} - NUM_W'(sample_q) + NUM_W'(max_sample_q >> 1);
	assign trial     = {rem_q, low_q[7]} - {1'b0, max_sample_q};
	assign scaled    = (max_sample_q == '0) ? 8'd0 : quo_q;
	assign bit_level = shift_q[7] ? 8'd0 : FULL_BYTE;

	assign status.bilevel        = packed_bilevel_q;
	assign status.first_half     = wide_sample && !high_pending_q;
	assign status.div_last       = (step_q == STEP_W'(QUO_W - 1));
	assign status.bits_last      = (bits_q == BITS_W'(1));
	assign status.pixel_complete = ({1'b0, channel_index_q} + DEPTH_W'(1)) >= depth_eff;
	assign status.out_free       = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packed_bilevel_q <= 1'b0;
			image_width_q    <= IMG_W_W'(1);
			channel_depth_q  <= DEPTH_W'(1);
			max_sample_q     <= MAX_DEFAULT;
			high_byte_q      <= '0;
			high_pending_q   <= 1'b0;
			channel_index_q  <= '0;
			column_q         <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_PACKED_BILEVEL: packed_bilevel_q <= cfg_data[0];
					REG_IMAGE_WIDTH:    image_width_q    <= cfg_data[IMG_W_W-1:0];
					REG_CHANNEL_DEPTH:  channel_depth_q  <= cfg_data[DEPTH_W-1:0];
					REG_MAX_SAMPLE:     max_sample_q     <= cfg_data[SAMPLE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.capture) begin
				if (packed_bilevel_q) begin
					column_q <= (col_next >= width_eff) ? '0 : COL_W'(col_next);
				end else if (wide_sample && !high_pending_q) begin
					high_byte_q    <= data_byte;
					high_pending_q <= 1'b1;
				end else if (wide_sample) begin
					high_pending_q <= 1'b0;
				end
			end
			if (cmd.hold_channel) begin
				channel_index_q <= channel_index_q + 2'd1;
			end
			if (cmd.emit_pixel) begin
				channel_index_q <= '0;
			end
			if (cmd.emit_pixel || cmd.emit_bit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			shift_q  <= data_byte;
			bits_q   <= count;
			sample_q <= (raw_sample > max_sample_q) ? max_sample_q : raw_sample;
		end
		if (cmd.prep) begin
			rem_q  <= numerator[NUM_W-1:8];
			low_q  <= numerator[7:0];
			step_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring step, one quotient bit a cycle
			if (!trial[SAMPLE_W]) begin
				rem_q <= trial[SAMPLE_W-1:0];
			end else begin
				rem_q <= {rem_q[SAMPLE_W-2:0], low_q[7]};
			end
			quo_q  <= {quo_q[QUO_W-2:0], !trial[SAMPLE_W]};
			low_q  <= {low_q[6:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.hold_channel) begin
			held_q[channel_index_q] <= scaled;
		end
		if (cmd.emit_bit) begin
			red_q   <= bit_level;
			green_q <= bit_level;
			blue_q  <= bit_level;
			alpha_q <= FULL_BYTE;
			last_q  <= (bits_q == BITS_W'(1));
			shift_q <= {shift_q[6:0], 1'b0};
			bits_q  <= bits_q - BITS_W'(1);
		end
		if (cmd.emit_pixel) begin
			last_q <= 1'b1;
			case (depth_eff)
				DEPTH_W'(1): begin
					red_q   <= scaled;
					green_q <= scaled;
					blue_q  <= scaled;
					alpha_q <= FULL_BYTE;
				end
				DEPTH_W'(2): begin
					red_q   <= held_q[0];
					green_q <= held_q[0];
					blue_q  <= held_q[0];
					alpha_q <= scaled;
				end
				DEPTH_W'(3): begin
					red_q   <= held_q[0];
					green_q <= held_q[1];
					blue_q  <= scaled;
					alpha_q <= FULL_BYTE;
				end
				default: begin
					red_q   <= held_q[0];
					green_q <= held_q[1];
					blue_q  <= held_q[2];
					alpha_q <= scaled;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign last_of_byte = last_q;

endmodule

### rtl/pnm_raster_decoder_unit.sv
// pnm raster decoder: raw raster bytes in, rgba8 pixels out
//
// Input channel: one raster byte per beat (in_valid / in_stall, data_byte).
// Output channel: one pixel per beat (red, green, blue, alpha, last_of_byte),
// last_of_byte marks the final pixel caused by an input byte.
// Configuration: cfg_write with cfg_index 0..3 selects packed_bilevel,
// image_width, channel_depth and max_sample; write only while the block is idle.
// A bilevel byte is accepted and then gives its pixels one by one (up to 8
// pixels, fewer at the row end). In sample mode the high byte of a two-byte
// sample is only captured and the input stays free for the next byte; a byte
// that completes a sample goes through accept, numerator set-up, 8 steps of
// the restoring divider that scales by max_sample (one quotient bit a
// cycle), and a final write.
// One output register parts the two sides: a finished pixel may wait there
// while the next byte is taken in. While the receiver stalls, the pixel holds
// and further emission waits; input is stalled until the byte is done.
// Reset puts the registers at their defaults (sample mode, width 1, depth 1,
// max 255), clears the row column, channel and two-byte pointers, and empties
// the output register.
module pnm_raster_decoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pnmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pnmrd_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [7:0]                         alpha,
	output logic                               last_of_byte
);
	import pnmrd_pkg::*;

	pnmrd_cmd_t    cmd;
	pnmrd_status_t status;

	pnmrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pnmrd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.last_of_byte (last_of_byte)
	);

endmodule

### rtl/pnmrd_checker.sv
// port checks for the pnm raster decoder, bound to the top level
module pnmrd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic       last_of_byte
);

	// a stalled pixel beat stays and holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({red, green, blue, alpha, last_of_byte}))
		else $error("stalled output beat changed");

	// only bilevel bytes give more than one pixel, and those are black or white
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_byte |-> alpha == 8'hFF && red == green
			&& green == blue && (red == 8'h00 || red == 8'hFF))
		else $error("non-final pixel is not plain black or white");

	// while a byte still owes pixels, no new byte is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_byte |-> in_stall)
		else $error("input taken while a byte is still being emitted");

	// input stall rises only after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stalled without an accepted beat");

endmodule

bind pnm_raster_decoder_unit pnmrd_checker u_pnmrd_checker (.*);

### tb/sv/pnm_raster_decoder_unit_checker.sv
// pixel predictor and scoreboard for the pnm raster decoder
module pnm_raster_decoder_unit_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pnmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pnmrd_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [7:0]                         red,
	input  logic [7:0]                         green,
	input  logic [7:0]                         blue,
	input  logic [7:0]                         alpha,
	input  logic                               last_of_byte,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 compared
);
	timeunit 1ns;
	timeprecision 1ps;
	import pnmrd_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} pixel_t;

	pixel_t expected_pixels[$];
	int errs;
	int seen;

	// shadow registers
	logic              bilevel_mode;
	logic [IMG_W_W-1:0] width_reg;
	logic [DEPTH_W-1:0] depth_reg;
	logic [SAMPLE_W-1:0] max_reg;

	// shadow decode state
	logic [7:0]  hi_byte;
	logic        hi_pending;
	int unsigned chan_idx;
	logic [7:0]  held[HELD_N];
	int unsigned col;

	function automatic logic [7:0] scale_sample(input int unsigned v, input int unsigned m);
		int unsigned num;
		if (m == 0)
			return 8'd0;
		if (v > m)
			v = m;
		if (m == 255)
			return v[7:0];
		num = v * 255 + m / 2;
		return 8'(num / m);
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		int unsigned w;
		int unsigned cnt;
		int unsigned d;
		int unsigned samp;
		int unsigned i;
		logic [7:0] s;
		logic [7:0] v;
		pixel_t p;
		if (bilevel_mode) begin
			w = width_reg;
			if (w == 0)
				w = 1;
			if (w > MAX_WIDTH)
				w = MAX_WIDTH;
			if (col >= w)
				col = 0;
			cnt = (w - col < 8) ? w - col : 8;
			for (i = 0; i < cnt; i++) begin
				// msb first, a set bit is black
				v = b[7 - i] ? 8'h00 : 8'hFF;
				p = '{v, v, v, 8'hFF, (i + 1 == cnt)};
				expected_pixels = {expected_pixels, p};
			end
			col += cnt;
			if (col >= w)
				col = 0;
			return;
		end
		d = depth_reg;
		if (d == 0)
			d = 1;
		if (d > 4)
			d = 4;
		if (max_reg > 255) begin
			if (!hi_pending) begin
				hi_byte = b;
				hi_pending = 1'b1;
				return;
			end
			hi_pending = 1'b0;
			samp = {hi_byte, b};
		end else begin
			samp = b;
		end
		s = scale_sample(samp, max_reg);
		if (chan_idx + 1 < d) begin
			held[chan_idx] = s;
			chan_idx = (chan_idx + 1) & 3;
			return;
		end
		// an overrun channel index after a depth change also lands here
		chan_idx = 0;
		case (d)
			1: p = '{s, s, s, 8'hFF, 1'b1};
			2: p = '{held[0], held[0], held[0], s, 1'b1};
			3: p = '{held[0], held[1], s, 8'hFF, 1'b1};
			default: p = '{held[0], held[1], held[2], s, 1'b1};
		endcase
		expected_pixels = {expected_pixels, p};
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			bilevel_mode = 1'b0;
			width_reg = 1;
			depth_reg = 1;
			max_reg = MAX_DEFAULT;
			hi_byte = 8'd0;
			hi_pending = 1'b0;
			chan_idx = 0;
			col = 0;
			for (int k = 0; k < HELD_N; k++)
				held[k] = 8'd0;
			expected_pixels.delete();
			errs = 0;
			seen = 0;
			fail_count <= 0;
			pending <= 0;
			compared <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {red, green, blue, alpha, last_of_byte};
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, got r=%h g=%h b=%h a=%h last=%b",
						$time, got.r, got.g, got.b, got.a, got.last);
					errs++;
				end else begin
					want = expected_pixels.pop_front();
					seen++;
					if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
						got.a !== want.a || got.last !== want.last) begin
						$display("%0t: pixel mismatch, expected r=%h g=%h b=%h a=%h last=%b",
							$time, want.r, want.g, want.b, want.a, want.last);
						$display("%0t: pixel mismatch, got r=%h g=%h b=%h a=%h last=%b",
							$time, got.r, got.g, got.b, got.a, got.last);
						errs++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_PACKED_BILEVEL: bilevel_mode = cfg_data[0];
					REG_IMAGE_WIDTH:    width_reg = cfg_data[IMG_W_W-1:0];
					REG_CHANNEL_DEPTH:  depth_reg = cfg_data[DEPTH_W-1:0];
					REG_MAX_SAMPLE:     max_reg = cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte);
			fail_count <= errs;
			pending <= expected_pixels.size();
			compared <= seen;
		end
	end

endmodule

### tb/sv/pnm_raster_decoder_unit_test.sv
// stimulus and verdict for the pnm raster decoder
module pnm_raster_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pnmrd_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic                 last_of_byte;

	int fails;
	int pending;
	int compared;
	bit idle_on;
	int bytes_sent;
	int settings;

	logic        cur_bilevel;
	int unsigned cur_width;
	int unsigned cur_depth;
	int unsigned cur_max;

	pnm_raster_decoder_unit dut (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .data_byte,
		.out_valid, .out_stall, .red, .green, .blue, .alpha, .last_of_byte
	);

	pnm_raster_decoder_unit_checker chk (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .data_byte,
		.out_valid, .out_stall, .red, .green, .blue, .alpha, .last_of_byte,
		.fail_count(fails), .pending(pending), .compared(compared)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver stalls in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// wait for every pixel, then for a byte that gives none to finish
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(val);
		@(posedge clk);
	endtask

	task automatic configure(input logic pb, input int unsigned w, input int unsigned d,
		input int unsigned m);
		settle();
		write_reg(REG_PACKED_BILEVEL, pb);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_CHANNEL_DEPTH, d);
		write_reg(REG_MAX_SAMPLE, m);
		cfg_write <= 1'b0;
		cur_bilevel = pb;
		cur_width = w;
		cur_depth = d;
		cur_max = m;
		settings++;
	endtask

	initial begin
		int unsigned rand_sent;
		int unsigned phase_len;
		int unsigned group;
		int unsigned w;
		int unsigned d;
		int unsigned m;
		logic pb;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		idle_on = 1'b1;
		bytes_sent = 0;
		settings = 1;
		rand_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: one-byte grey passes straight through
		send_byte(8'h00);
		send_byte(8'hFF);
		// rgba fills every held channel before anything reads one
		configure(0, 1, 4, 255);
		send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
		// zero maximum scales everything to zero
		configure(0, 1, 2, 0);
		send_byte(8'hFF); send_byte(8'h80);
		// out-of-range depth, two-byte samples with clamping, high byte left waiting
		configure(0, 1, 7, 1000);
		send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'h01); send_byte(8'hF4);
		send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h03);
		// bilevel with zero depth, row padding dropped
		configure(1, 3, 0, 1000);
		send_byte(8'hA0); send_byte(8'h5F);
		configure(1, 10, 1, 255);
		send_byte(8'hFF);
		// column beyond the narrower row restarts at zero
		configure(1, 4, 1, 255);
		send_byte(8'h0F);
		// waiting high byte and an overrun channel index complete a pixel
		configure(0, 1, 2, 1000);
		send_byte(8'hE8);
		// zero width counts as one, oversize width is capped
		configure(1, 0, 1, 65535);
		send_byte(8'h80);
		configure(1, 32767, 4, 65535);
		send_byte(8'h3C);
		configure(0, 1, 1, 65535);
		send_byte(8'h12); send_byte(8'h34); send_byte(8'hFF); send_byte(8'hFF);

		while (rand_sent < 345) begin
			pb = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 4))
					0: w = 0;
					1: w = 1;
					2: w = MAX_WIDTH;
					3: w = MAX_WIDTH + 1;
					default: w = 32767;
				endcase
			end else begin
				w = $urandom_range(1, 24);
			end
			d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			case ($urandom_range(0, 7))
				0, 1: m = 255;
				2: m = $urandom_range(1, 254);
				3: m = $urandom_range(256, 65535);
				4: m = 65535;
				5: m = 1;
				6: m = $urandom_range(256, 1023);
				default: m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 300);
			endcase
			configure(pb, w, d, m);
			// no idling towards the end, some phases without it too
			idle_on = (rand_sent < 280) && ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(15, 40);
			while (phase_len > 0 && rand_sent < 345) begin
				w = (cur_width == 0) ? 1 : cur_width;
				d = (cur_depth == 0) ? 1 : (cur_depth > 4) ? 4 : cur_depth;
				if ($urandom_range(0, 7) == 0)
					group = $urandom_range(1, 3);
				else if (cur_bilevel)
					group = (w <= 64) ? (w + 7) / 8 : $urandom_range(1, 8);
				else
					group = d * ((cur_max > 255) ? 2 : 1);
				repeat (group) begin
					case ($urandom_range(0, 7))
						0: send_byte(8'h00);
						1: send_byte(8'hFF);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
					rand_sent++;
				end
				phase_len = (phase_len > group) ? phase_len - group : 0;
			end
		end

		settle();
		$display("raster decode: %0d bytes under %0d register settings, bilevel rows and",
			bytes_sent, settings);
		$display("one- and two-byte samples at depths 1-4; %0d pixels compared", compared);
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
